// ===== sv/aas_pkg.sv =====
// Shared types and constants for the autoranging axis scaler.
`timescale 1ns / 1ps

package aas_pkg;

  localparam int RAW_W    = 16;
  localparam int SMP_W    = 12;
  localparam int POS_W    = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IX_W = 1;
  localparam int NUM_W    = 2 * SMP_W;   // magnitude of the product
  localparam int DIV_STEPS = NUM_W / 2;  // two quotient bits per cycle
  localparam int CNT_W    = $clog2(DIV_STEPS);

  typedef logic [RAW_W-1:0]           raw_t;
  typedef logic [SMP_W-1:0]           sample_t;
  typedef logic signed [POS_W-1:0]    pos_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;
  typedef logic [CFG_IX_W-1:0]        cfg_index_t;

  localparam cfg_index_t REG_OUT_LOW  = 1'd0;
  localparam cfg_index_t REG_OUT_HIGH = 1'd1;

  localparam sample_t   RESET_MAX      = 12'd1600;
  localparam sample_t   RESET_MIN      = 12'd10;
  localparam cfg_data_t RESET_OUT_LOW  = 12'hE0C;  // -500
  localparam cfg_data_t RESET_OUT_HIGH = 12'h1F4;  //  500

  // byte swap, then drop the low nibble
  function automatic sample_t extract_sample(input raw_t raw);
    logic [RAW_W-1:0] swapped;
    swapped = {raw[7:0], raw[15:8]};
    return swapped[RAW_W-1:RAW_W-SMP_W];
  endfunction

endpackage

// ===== sv/autoranging_axis_scaler.sv =====
// Autoranging axis scaler: bound tracking, multiply and radix-4 divide sequencer.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_ready, axis, raw_word        | in
//  out     | out_valid, out_ready, position, sample    | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Each word is accepted in idle and then passes through the bound update,
// the multiply, the shared divider (two quotient bits per cycle over a 24-bit
// magnitude) and the finish state before the sequencer returns to idle.
// in_ready is high only while the sequencer is idle. Reset restores the
// per-axis bounds and the output range. A result waiting in the output
// register holds the finish state until it is taken; cfg_ready is always
// high.
`timescale 1ns / 1ps

module autoranging_axis_scaler (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                axis,
  input  aas_pkg::raw_t       raw_word,
  output logic                out_valid,
  input  logic                out_ready,
  output aas_pkg::pos_t       position,
  output aas_pkg::sample_t    sample,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  aas_pkg::cfg_index_t cfg_index,
  input  aas_pkg::cfg_data_t  cfg_data
);
  import aas_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BOUND = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;

  cfg_data_t out_low, out_high;
  sample_t   axis_max [2];
  sample_t   axis_min [2];

  logic      ax;
  sample_t   smp;
  sample_t   span;
  sample_t   diff;
  sample_t   rng_mag;
  logic      rng_neg;
  logic [NUM_W-1:0] quo;
  sample_t   rem;

  // bound update
  sample_t cur_max, cur_min, max_next, min_next;
  logic signed [CFG_W:0] rng;
  logic signed [CFG_W:0] rng_abs;

  always_comb begin
    cur_max  = axis_max[ax];
    cur_min  = axis_min[ax];
    max_next = cur_max;
    min_next = cur_min;
    if (smp > cur_max) begin
      max_next = smp;
    end else if (smp < cur_min) begin
      min_next = smp;
    end
    rng     = $signed({out_high[CFG_W-1], out_high}) - $signed({out_low[CFG_W-1], out_low});
    rng_abs = rng[CFG_W] ? -rng : rng;
  end

  // two restoring divide steps per cycle
  logic [SMP_W:0] r1, r2;
  sample_t        rem1, rem_next;
  logic           qb1, qb2;

  always_comb begin
    r1   = {rem, quo[NUM_W-1]};
    qb1  = (r1 >= {1'b0, span});
    rem1 = qb1 ? SMP_W'(r1 - {1'b0, span}) : r1[SMP_W-1:0];
    r2   = {rem1, quo[NUM_W-2]};
    qb2  = (r2 >= {1'b0, span});
    rem_next = qb2 ? SMP_W'(r2 - {1'b0, span}) : r2[SMP_W-1:0];
  end

  // sign, offset, Y negation and clamp
  logic signed [NUM_W:0]   q_s;
  logic signed [NUM_W+1:0] pos_sum;
  logic signed [NUM_W+2:0] pos_fin;
  pos_t                    pos_sat;

  always_comb begin
    if (span == '0) begin
      q_s = '0;
    end else if (rng_neg) begin
      q_s = -$signed({1'b0, quo});
    end else begin
      q_s = $signed({1'b0, quo});
    end
    pos_sum = (NUM_W+2)'(q_s) + (NUM_W+2)'($signed(out_low));
    pos_fin = ax ? -(NUM_W+3)'(pos_sum) : (NUM_W+3)'(pos_sum);
    if (pos_fin > (NUM_W+3)'(2047)) begin
      pos_sat = 12'sh7FF;
    end else if (pos_fin < -(NUM_W+3)'(2048)) begin
      pos_sat = 12'sh800;
    end else begin
      pos_sat = pos_fin[POS_W-1:0];
    end
  end

  logic out_load;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      out_valid   <= 1'b0;
      out_low     <= RESET_OUT_LOW;
      out_high    <= RESET_OUT_HIGH;
      axis_max[0] <= RESET_MAX;
      axis_max[1] <= RESET_MAX;
      axis_min[0] <= RESET_MIN;
      axis_min[1] <= RESET_MIN;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OUT_LOW:  out_low  <= cfg_data;
          REG_OUT_HIGH: out_high <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_BOUND;
          end
        end
        S_BOUND: begin
          axis_max[ax] <= max_next;
          axis_min[ax] <= min_next;
          state        <= S_MUL;
        end
        S_MUL: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ax  <= axis;
        smp <= extract_sample(raw_word);
      end
      S_BOUND: begin
        span    <= max_next - min_next;
        diff    <= smp - min_next;
        rng_neg <= rng[CFG_W];
        rng_mag <= rng_abs[SMP_W-1:0];
      end
      S_MUL: begin
        quo <= diff * rng_mag;
        rem <= '0;
      end
      S_DIV: begin
        rem <= rem_next;
        quo <= {quo[NUM_W-3:0], qb1, qb2};
      end
      S_FIN: begin
        if (out_load) begin
          position <= pos_sat;
          sample   <= smp;
        end
      end
      default: ;
    endcase
  end

  // bounds never move inside their reset values
  assert property (@(posedge clk) disable iff (rst)
    axis_max[0] >= RESET_MAX && axis_max[1] >= RESET_MAX &&
    axis_min[0] <= RESET_MIN && axis_min[1] <= RESET_MIN)
    else $error("axis bounds crossed reset values");

  // partial remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < span)
    else $error("divider remainder out of range");

  // a word only enters when idle, and blocks the next one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_BOUND && !in_ready)
    else $error("input taken outside idle");

  // a new result only comes from the finish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside finish");

endmodule

// ===== sim/tb_autoranging_axis_scaler.sv =====
// Self-checking testbench for the autoranging axis scaler: directed table, then random words.
`timescale 1ns / 1ps

module tb_autoranging_axis_scaler;
  import aas_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SEG_ITEMS   = 315;
  localparam int N_SEGS      = 6;
  localparam int N_DIR       = 30;
  localparam int DRAIN_CYC   = 32;
  localparam int MAX_REPORTS = 10;
  localparam int POS_MAX     = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN     = -(2 ** (POS_W - 1));
  localparam int SMP_TOP     = 2 ** SMP_W - 1;

  localparam cfg_data_t FULL_LO = 12'h800;  // -2048
  localparam cfg_data_t FULL_HI = 12'h7FF;  //  2047
  localparam cfg_data_t CFG_ZERO = 12'h000;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       ax;
    raw_t       raw;
    cfg_index_t ix;
    cfg_data_t  val;
    logic       typed;
    pos_t       pos;
    sample_t    smp;
  } stim_row_t;

  typedef struct packed {
    pos_t    pos;
    sample_t smp;
  } scaled_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid;
  logic       in_ready;
  logic       axis;
  raw_t       raw_word;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pos_t       position;
  sample_t    sample;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_index_t cfg_index;
  cfg_data_t  cfg_data;

  // tracked bounds and output range, mirrored from the block
  sample_t trk_max [2];
  sample_t trk_min [2];
  int      range_lo;
  int      range_hi;

  scaled_t   scaled_q [$];
  int        err_cnt = 0;
  int        tx_idle_pct = 21;
  int        rx_idle_pct = 84;
  stim_row_t dir_tab [N_DIR];

  autoranging_axis_scaler uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .axis      (axis),
    .raw_word  (raw_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .sample    (sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample is the upper 12 bits of the byte-swapped word
  function automatic sample_t unswap_sample(raw_t r);
    return {r[7:0], r[15:12]};
  endfunction

  function automatic raw_t make_raw(sample_t s, logic [3:0] nib);
    return {s[3:0], nib, s[11:4]};
  endfunction

  function automatic pos_t track_and_rescale(logic ax, sample_t s);
    int span, num, q, p;
    if (s > trk_max[ax]) trk_max[ax] = s;
    else if (s < trk_min[ax]) trk_min[ax] = s;
    span = int'(trk_max[ax]) - int'(trk_min[ax]);
    num  = (int'(s) - int'(trk_min[ax])) * (range_hi - range_lo);
    q    = (span != 0) ? num / span : 0;  // truncates toward zero
    p    = q + range_lo;
    if (ax) p = -p;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    return pos_t'(p);
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_word(logic ax, raw_t r, logic typed, pos_t ep, sample_t es);
    scaled_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    axis     <= ax;
    raw_word <= r;
    do @(posedge clk); while (!in_ready);
    res.smp = unswap_sample(r);
    res.pos = track_and_rescale(ax, res.smp);
    if (typed) begin
      res.pos = ep;
      res.smp = es;
    end
    scaled_q.push_back(res);
    @(negedge clk);
  endtask

  // only once the block has drained
  task automatic write_reg(cfg_index_t ix, cfg_data_t d);
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (ix == REG_OUT_LOW) range_lo = int'($signed(d));
    else range_hi = int'($signed(d));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

  always @(posedge clk) begin : check_out
    scaled_t want;
    if (!rst && out_valid && out_ready) begin
      if (scaled_q.size() == 0) begin
        if (err_cnt < MAX_REPORTS)
          $display("unexpected word: position %0d sample %0d", position, sample);
        err_cnt++;
      end else begin
        want = scaled_q.pop_front();
        if (position !== want.pos || sample !== want.smp) begin
          if (err_cnt < MAX_REPORTS)
            $display("mismatch: position exp %0d got %0d, sample exp %0d got %0d",
                     want.pos, position, want.smp, sample);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    int        seg, n, sel, room;
    logic      ax;
    sample_t   s;
    raw_t      r;
    cfg_data_t lo_v, hi_v;
    in_valid  = 1'b0;
    axis      = 1'b0;
    raw_word  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OUT_LOW;
    cfg_data  = '0;
    range_lo  = int'($signed(RESET_OUT_LOW));
    range_hi  = int'($signed(RESET_OUT_HIGH));
    trk_max[0] = RESET_MAX;
    trk_max[1] = RESET_MAX;
    trk_min[0] = RESET_MIN;
    trk_min[1] = RESET_MIN;

    // kind, axis, raw, reg, data, typed, position, sample
    dir_tab = '{
      '{ROW_WORD, 1'b0, 16'h0000, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'hE0C, 12'h000},
      '{ROW_WORD, 1'b0, 16'hFFFF, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h1F4, 12'hFFF},
      '{ROW_WORD, 1'b1, 16'h0064, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'hE0C, 12'h640},
      '{ROW_WORD, 1'b1, 16'hA000, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h1F4, 12'h00A},
      '{ROW_WORD, 1'b1, 16'h5732, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_LOW,  FULL_LO,  1'b0, 12'h000, 12'h000},
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_HIGH, FULL_HI,  1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b0, 16'hFFFF, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h7FF, 12'hFFF},
      '{ROW_WORD, 1'b0, 16'h0000, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h800, 12'h000},
      // Y at its minimum: negated low end saturates
      '{ROW_WORD, 1'b1, 16'hA000, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h7FF, 12'h00A},
      '{ROW_WORD, 1'b1, 16'h0064, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h801, 12'h640},
      // inverted range
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_LOW,  FULL_HI,  1'b0, 12'h000, 12'h000},
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_HIGH, FULL_LO,  1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b0, 16'h0000, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h7FF, 12'h000},
      '{ROW_WORD, 1'b0, 16'hFFFF, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h800, 12'hFFF},
      '{ROW_WORD, 1'b1, 16'hA000, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h801, 12'h00A},
      '{ROW_WORD, 1'b1, 16'h0064, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h7FF, 12'h640},
      '{ROW_WORD, 1'b0, 16'h5A3C, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b0, 16'hA5C3, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b1, 16'h3C5A, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      // zero-width output range
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_HIGH, CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b0, 16'h1234, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h000, 12'h341},
      '{ROW_WORD, 1'b1, 16'h1234, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'h000, 12'h341},
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_LOW,  RESET_OUT_LOW,  1'b0, 12'h000, 12'h000},
      '{ROW_CFG,  1'b0, 16'h0000, REG_OUT_HIGH, RESET_OUT_HIGH, 1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b0, 16'h8000, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b1, 16'h0064, REG_OUT_LOW,  CFG_ZERO, 1'b1, 12'hE0C, 12'h640},
      // Y widens downwards, then upwards by one
      '{ROW_WORD, 1'b1, 16'h5000, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000},
      '{ROW_WORD, 1'b1, 16'h1064, REG_OUT_LOW,  CFG_ZERO, 1'b0, 12'h000, 12'h000}
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_reg(dir_tab[i].ix, dir_tab[i].val);
      else
        send_word(dir_tab[i].ax, dir_tab[i].raw, dir_tab[i].typed,
                  dir_tab[i].pos, dir_tab[i].smp);
    end

    for (seg = 0; seg < N_SEGS; seg++) begin
      case (seg)
        0: begin
          lo_v = FULL_LO;
          hi_v = FULL_HI;
        end
        2: begin
          lo_v = FULL_HI;
          hi_v = FULL_LO;
        end
        5: begin
          lo_v = RESET_OUT_LOW;
          hi_v = RESET_OUT_HIGH;
        end
        default: begin
          lo_v = cfg_data_t'($urandom_range(0, SMP_TOP));
          hi_v = cfg_data_t'($urandom_range(0, SMP_TOP));
        end
      endcase
      write_reg(REG_OUT_LOW, lo_v);
      write_reg(REG_OUT_HIGH, hi_v);
      tx_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 84 : 0;
      rx_idle_pct = (seg < 2) ? 84 : (seg < 4) ? 21 : 0;

      for (n = 0; n < SEG_ITEMS; n++) begin
        ax   = 1'($urandom_range(0, 1));
        sel  = $urandom_range(0, 99);
        room = SMP_TOP - int'(trk_max[ax]);
        // mostly inside the tracked span, with slow widening at both ends
        if (sel < 12 && room > 0)
          s = trk_max[ax] + sample_t'($urandom_range(1, (room < 24) ? room : 24));
        else if (sel < 16 && trk_min[ax] != '0)
          s = trk_min[ax] - 1'b1;
        else
          s = sample_t'($urandom_range(int'(trk_min[ax]), int'(trk_max[ax])));
        r = make_raw(s, 4'($urandom_range(0, 15)));
        if (sel >= 97) r = raw_t'($urandom());
        send_word(ax, r, 1'b0, '0, '0);
      end
    end

    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (err_cnt == 0 && scaled_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/aas_pkg.sv
sv/autoranging_axis_scaler.sv
sim/tb_autoranging_axis_scaler.sv
